[rtl/core/gwe_pkg.sv]
`timescale 1ns / 1ps

package gwe_pkg;

  localparam int COEF_W  = 24;
  localparam int OFS_W   = 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int HGT_W   = 16;
  localparam int COORD_W = 16;
  // Products and sums are kept exact: a 24-bit coefficient times an
  // 11-bit (zero-extended) index, or times a 16-bit height.
  localparam int PROD_IDX_W = COEF_W + COL_W + 1;
  localparam int PROD_HGT_W = COEF_W + HGT_W;
  localparam int SUM_W      = PROD_HGT_W + 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_COEF_COL_X    = 3'd0;
  localparam logic [2:0] REG_COEF_ROW_X    = 3'd1;
  localparam logic [2:0] REG_COEF_HEIGHT_X = 3'd2;
  localparam logic [2:0] REG_COEF_COL_Y    = 3'd3;
  localparam logic [2:0] REG_COEF_ROW_Y    = 3'd4;
  localparam logic [2:0] REG_COEF_HEIGHT_Y = 3'd5;
  localparam logic [2:0] REG_OFFSET_X      = 3'd6;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd7;

  typedef enum logic [0:0] {
    EDGE_H = 1'b0,
    EDGE_V = 1'b1
  } edge_kind_t;

  // Projected screen point, x in the low half.
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

endpackage

[rtl/core/gwe_row_buffer.sv]
`timescale 1ns / 1ps

module gwe_row_buffer
  import gwe_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  point_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output point_t            rdata
);

  point_t mem [DEPTH];

  // Read-first: a read and a write to the same entry in one cycle return
  // the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/grid_wireframe_edge_projector.sv]
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   40     grid point word: col, row, height
// m_axis    out  64+1+1 segment word: begin/end points, tuser edge kind, tlast
// apb       in   5/32   coefficient and offset registers, byte address 4*i
//
// One grid point is accepted per cycle while the output is not stalled; a point
// with both a left and an upper neighbour keeps stage 4 for its second segment,
// since the output port moves one segment a cycle. A point's first segment reaches
// the port through the capture register, the products, the sums with the
// line-buffer read, the neighbour select and the output register.
// Reset clears the pipeline valids and the registers; the line buffer and the
// left point are not cleared.
// While m_tready is low the word on the port holds and the four stages
// behind it keep filling before s_tready drops.

module grid_wireframe_edge_projector
  import gwe_pkg::*;
#(
  parameter int MAX_COLS  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // fields from bit 0: col[9:0], row[19:10], height[35:20], zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,
  // fields from bit 0: begin_x, begin_y, end_x, end_y
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,
  // fields from bit 0: edge_kind
  output logic [0:0]            m_tuser,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Column modulo the line-buffer depth: restoring compare and subtract
  // against the depth shifted left by hi down to lo.
  function automatic logic [COL_W-1:0] col_mod_steps(input logic [COL_W-1:0] v,
                                                     input int hi, input int lo);
    logic [COL_W-1:0] r;
    r = v;
    for (int k = hi; k >= lo; k--) begin
      if ((MAX_COLS << k) < (1 << COL_W)) begin
        if (r >= COL_W'(MAX_COLS << k)) begin
          r = r - COL_W'(MAX_COLS << k);
        end
      end
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [COEF_W-1:0] coef_col_x, coef_row_x, coef_height_x;
  logic signed [COEF_W-1:0] coef_col_y, coef_row_y, coef_height_y;
  logic signed [OFS_W-1:0]  offset_x, offset_y;
  logic                     cfg_we;
  logic [2:0]               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_col_x    <= '0;
      coef_row_x    <= '0;
      coef_height_x <= '0;
      coef_col_y    <= '0;
      coef_row_y    <= '0;
      coef_height_y <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_COL_X:    coef_col_x    <= pwdata[COEF_W-1:0];
        REG_COEF_ROW_X:    coef_row_x    <= pwdata[COEF_W-1:0];
        REG_COEF_HEIGHT_X: coef_height_x <= pwdata[COEF_W-1:0];
        REG_COEF_COL_Y:    coef_col_y    <= pwdata[COEF_W-1:0];
        REG_COEF_ROW_Y:    coef_row_y    <= pwdata[COEF_W-1:0];
        REG_COEF_HEIGHT_Y: coef_height_y <= pwdata[COEF_W-1:0];
        REG_OFFSET_X:      offset_x      <= pwdata;
        REG_OFFSET_Y:      offset_y      <= pwdata;
        default:           offset_y      <= offset_y;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COEF_COL_X:    prdata = APB_DATA_W'(coef_col_x);
      REG_COEF_ROW_X:    prdata = APB_DATA_W'(coef_row_x);
      REG_COEF_HEIGHT_X: prdata = APB_DATA_W'(coef_height_x);
      REG_COEF_COL_Y:    prdata = APB_DATA_W'(coef_col_y);
      REG_COEF_ROW_Y:    prdata = APB_DATA_W'(coef_row_y);
      REG_COEF_HEIGHT_Y: prdata = APB_DATA_W'(coef_height_y);
      REG_OFFSET_X:      prdata = offset_x;
      REG_OFFSET_Y:      prdata = offset_y;
      default:           prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage takes a new word when it is empty or its
  // word moves on in the same cycle.
  logic v1, v2, v3, v4;
  logic free1, free2, free3, free4;
  logic ld1, ld2, ld3, ld4;
  logic done4;

  assign free4 = !v4 || done4;
  assign free3 = !v3 || free4;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;
  assign s_tready = free1;

  assign ld1 = s_tvalid && free1;
  assign ld2 = v1 && free2;
  assign ld3 = v2 && free3;
  assign ld4 = v3 && free4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ld1 || (v1 && !free2);
      v2 <= ld2 || (v2 && !free3);
      v3 <= ld3 || (v3 && !free4);
      v4 <= ld4 || (v4 && !done4);
    end
  end

  // Stage 1: captured grid point
  logic [COL_W-1:0]        col1;
  logic [COL_W-1:0]        col_part1;
  logic [ROW_W-1:0]        row1;
  logic signed [HGT_W-1:0] height1;

  always_ff @(posedge clk) begin
    if (ld1) begin
      col1      <= s_tdata[COL_W-1:0];
      col_part1 <= col_mod_steps(s_tdata[COL_W-1:0], COL_W - 1, COL_W / 2);
      row1      <= s_tdata[COL_W+ROW_W-1:COL_W];
      height1   <= s_tdata[COL_W+ROW_W+HGT_W-1:COL_W+ROW_W];
    end
  end

  // Stage 2: six products and the line-buffer index
  logic signed [PROD_IDX_W-1:0] p_cx2, p_rx2, p_cy2, p_ry2;
  logic signed [PROD_HGT_W-1:0] p_hx2, p_hy2;
  logic [IDX_W-1:0]             idx2;
  logic                         need_h2, need_v2;
  logic [IDX_W-1:0]             idx_calc;
  logic signed [COL_W:0]        col_s;
  logic signed [ROW_W:0]        row_s;

  assign col_s = $signed({1'b0, col1});
  assign row_s = $signed({1'b0, row1});

  // The upper half of the column reduction was done on capture.
  assign idx_calc = IDX_W'(col_mod_steps(col_part1, COL_W / 2 - 1, 0));

  always_ff @(posedge clk) begin
    if (ld2) begin
      p_cx2   <= coef_col_x * col_s;
      p_rx2   <= coef_row_x * row_s;
      p_hx2   <= coef_height_x * height1;
      p_cy2   <= coef_col_y * col_s;
      p_ry2   <= coef_row_y * row_s;
      p_hy2   <= coef_height_y * height1;
      idx2    <= idx_calc;
      need_h2 <= (col1 != '0);
      need_v2 <= (row1 != '0);
    end
  end

  // Stage 3: exact sums; the line-buffer read is issued on entry
  logic signed [SUM_W-1:0] sum_x3, sum_y3;
  logic [IDX_W-1:0]        idx3;
  logic                    need_h3, need_v3;
  logic                    fwd3;
  point_t                  fwd_pt3;
  point_t                  cur3;
  point_t                  rd_pt;

  always_ff @(posedge clk) begin
    if (ld3) begin
      sum_x3  <= SUM_W'(offset_x) + SUM_W'(p_cx2) + SUM_W'(p_rx2) + SUM_W'(p_hx2);
      sum_y3  <= SUM_W'(offset_y) + SUM_W'(p_cy2) + SUM_W'(p_ry2) + SUM_W'(p_hy2);
      idx3    <= idx2;
      need_h3 <= need_h2;
      need_v3 <= need_v2;
      // The word leaving stage 3 in this cycle writes the entry being read.
      fwd3    <= ld4 && (idx3 == idx2);
      fwd_pt3 <= cur3;
    end
  end

  // Floor is an arithmetic shift; then saturate to 16-bit signed.
  logic signed [SUM_W-1:0] q_x, q_y;
  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(1 << (COORD_W - 1));

  assign q_x = sum_x3 >>> FRAC_BITS;
  assign q_y = sum_y3 >>> FRAC_BITS;

  always_comb begin
    if (q_x > COORD_MAX) begin
      cur3.x = COORD_MAX[COORD_W-1:0];
    end else if (q_x < COORD_MIN) begin
      cur3.x = COORD_MIN[COORD_W-1:0];
    end else begin
      cur3.x = q_x[COORD_W-1:0];
    end
    if (q_y > COORD_MAX) begin
      cur3.y = COORD_MAX[COORD_W-1:0];
    end else if (q_y < COORD_MIN) begin
      cur3.y = COORD_MIN[COORD_W-1:0];
    end else begin
      cur3.y = q_y[COORD_W-1:0];
    end
  end

  gwe_row_buffer #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (IDX_W)
  ) u_row_buffer (
    .clk   (clk),
    .we    (ld4),
    .waddr (idx3),
    .wdata (cur3),
    .re    (ld3),
    .raddr (idx2),
    .rdata (rd_pt)
  );

  // Stage 4: finished point with both neighbours, emits its segments
  point_t left_point;
  point_t cur4, left4, up4;
  logic   need_h4, need_v4, sent_h4;

  always_ff @(posedge clk) begin
    if (ld4) begin
      left_point <= cur3;
      cur4       <= cur3;
      left4      <= left_point;
      up4        <= fwd3 ? fwd_pt3 : rd_pt;
      need_h4    <= need_h3;
      need_v4    <= need_v3;
    end
  end

  logic out_free, emit_h, emit_v, fire, no_res;

  assign out_free = !m_tvalid || m_tready;
  assign emit_h   = v4 && need_h4 && !sent_h4;
  assign emit_v   = v4 && need_v4 && !emit_h;
  assign fire     = (emit_h || emit_v) && out_free;
  assign no_res   = v4 && !need_h4 && !need_v4;
  assign done4    = no_res || (fire && (emit_v || !need_v4));

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_h4 <= 1'b0;
    end else if (ld4) begin
      sent_h4 <= 1'b0;
    end else if (emit_h && out_free) begin
      sent_h4 <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {cur4, (emit_h ? left4 : up4)};
      m_tuser <= emit_h ? EDGE_H : EDGE_V;
      m_tlast <= emit_v || !need_v4;
    end
  end

endmodule

[rtl/core/gwe_checker.sv]
`timescale 1ns / 1ps

module gwe_checker
  import gwe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Only a left edge can be followed by another segment of the same point.
  a_notlast_h: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == EDGE_H)
    else $error("non-final segment is not a left edge");

  // The upper edge follows its left edge in the very next cycle.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tuser == EDGE_V)
    else $error("upper edge did not follow left edge");

  // Both segments of one point end at the same screen position.
  a_same_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tdata[63:32] == $past(m_tdata[63:32]))
    else $error("segment pair ends at different points");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind grid_wireframe_edge_projector gwe_checker u_gwe_checker (.*);

[tb/tb_grid_wireframe_edge_projector.sv]
`timescale 1ns / 1ps

module tb_grid_wireframe_edge_projector;
  import gwe_pkg::*;

  localparam int MAX_COLS     = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int DRAIN_CYCLES = 12;
  localparam int HANG_LIMIT   = 2000;

  typedef struct {
    logic signed [COORD_W-1:0] begin_x;
    logic signed [COORD_W-1:0] begin_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    edge_kind_t                kind;
    logic                      last_of_run;
  } segment_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the block: register values, previous point and the line above.
  longint   reg_val [8];
  point_t   left_pt;
  bit       left_valid;
  point_t   line_buf [MAX_COLS];
  bit       col_written [MAX_COLS];
  logic [31:0] cfg_words [8];

  segment_t pending_segments [$];
  segment_t head_seg;
  int       mismatches  = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  bit       steady      = 1'b0;

  grid_wireframe_edge_projector #(
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
      stall_left <= idle_len();
    end
  end

  // Exact sum, floored by the arithmetic shift, then clipped to 16 bits.
  function automatic logic signed [COORD_W-1:0] floor_clip(longint sum);
    longint q;
    q = sum >>> FRAC_BITS;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[COORD_W-1:0];
  endfunction

  function automatic point_t project_point(logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                           logic signed [HGT_W-1:0] h);
    point_t p;
    p.x = floor_clip(reg_val[REG_OFFSET_X] + reg_val[REG_COEF_COL_X] * longint'(c)
                     + reg_val[REG_COEF_ROW_X] * longint'(r)
                     + reg_val[REG_COEF_HEIGHT_X] * longint'(h));
    p.y = floor_clip(reg_val[REG_OFFSET_Y] + reg_val[REG_COEF_COL_Y] * longint'(c)
                     + reg_val[REG_COEF_ROW_Y] * longint'(r)
                     + reg_val[REG_COEF_HEIGHT_Y] * longint'(h));
    return p;
  endfunction

  function automatic void predict_segments(logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                           logic signed [HGT_W-1:0] h);
    point_t   cur;
    segment_t seg;
    cur = project_point(c, r, h);
    if (c != 0) begin
      seg = '{left_pt.x, left_pt.y, cur.x, cur.y, EDGE_H, (r == 0)};
      pending_segments.push_back(seg);
    end
    if (r != 0) begin
      seg = '{line_buf[c].x, line_buf[c].y, cur.x, cur.y, EDGE_V, 1'b1};
      pending_segments.push_back(seg);
    end
    left_pt        = cur;
    left_valid     = 1'b1;
    line_buf[c]    = cur;
    col_written[c] = 1'b1;
  endfunction

  // Sends one grid point. A point whose neighbour was never stored is
  // pulled back onto the grid edge so that no unwritten entry is read.
  task automatic send_point(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                            input logic signed [HGT_W-1:0] h);
    int gap;
    if (!left_valid) c = '0;
    if (r != 0 && !col_written[c]) r = '0;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, h, r, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_segments(c, r, h);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    logic signed [COEF_W-1:0] coef24;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    coef24 = data[COEF_W-1:0];
    reg_val[idx] = (idx < REG_OFFSET_X) ? longint'(coef24) : longint'(signed'(data));
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) write_reg(3'(i), cfg_words[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lets every pending segment out, then gives the pipeline time to flush
  // points that make no segment before the registers change.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void random_config(int style);
    logic signed [COEF_W-1:0] c24;
    logic [31:0]              word;
    int                       pick;
    int                       px;
    for (int i = 0; i < 6; i++) begin
      pick = $urandom_range(0, 9);
      if (style == 0 || (style == 2 && pick == 6)) c24 = 24'h7FFFFF;
      else if (style == 1 || pick == 7) c24 = 24'h800000;
      else if (pick >= 8) c24 = 24'($urandom);
      else begin
        c24 = 24'($urandom_range(0, 1 << 21));
        if ($urandom_range(0, 1) == 1) c24 = -c24;
      end
      word = {{8{c24[COEF_W-1]}}, c24};
      // The upper byte of a coefficient word is ignored by the block.
      if ($urandom_range(0, 7) == 0) word[31:24] = 8'($urandom);
      cfg_words[i] = word;
    end
    for (int i = 6; i < 8; i++) begin
      px = int'($urandom_range(0, 1400)) - 200;
      if (style == 0) word = 32'h7FFFFFFF;
      else if (style == 1) word = 32'h80000000;
      else if ($urandom_range(0, 9) < 7) word = (px << 16) | ($urandom & 32'hFFFF);
      else word = $urandom;
      cfg_words[i] = word;
    end
  endfunction

  function automatic logic signed [HGT_W-1:0] rand_height();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 16'(int'($urandom_range(0, 128)) - 64);
    if (pick < 9) return 16'(int'($urandom_range(0, 8191)) - 4096);
    return 16'($urandom);
  endfunction

  // All registers at their reset value: every point lands on the origin.
  task automatic test_reset_state();
    send_point(10'd0, 10'd0, 16'sd100);
    send_point(10'd1, 10'd0, -16'sd100);
    send_point(10'd0, 10'd1, 16'sd32767);
    send_point(10'd1, 10'd1, -16'sd32768);
  endtask

  // Extreme coefficients and offsets, grid corners and the largest indices.
  task automatic test_grid_edges();
    wait_quiet();
    cfg_words[REG_COEF_COL_X]    = 32'h007FFFFF;
    cfg_words[REG_COEF_ROW_X]    = 32'hFF800000;
    cfg_words[REG_COEF_HEIGHT_X] = 32'h00000001;
    cfg_words[REG_COEF_COL_Y]    = 32'hFF800000;
    cfg_words[REG_COEF_ROW_Y]    = 32'h007FFFFF;
    cfg_words[REG_COEF_HEIGHT_Y] = 32'hFFFFFFFF;
    cfg_words[REG_OFFSET_X]      = 32'h7FFFFFFF;
    cfg_words[REG_OFFSET_Y]      = 32'h80000000;
    program_regs();
    send_point(10'd0, 10'd0, 16'sd0);
    send_point(10'd1023, 10'd0, 16'sd32767);
    send_point(10'd512, 10'd0, -16'sd32768);
    send_point(10'd512, 10'd1023, 16'sd0);
    send_point(10'd1023, 10'd1, -16'sd32768);
    send_point(10'd0, 10'd1, -16'sd1);
    send_point(10'd1023, 10'd1023, 16'sd1);
  endtask

  // Fractional coefficients, so flooring of negative sums shows up.
  task automatic test_fraction_floor();
    logic signed [HGT_W-1:0] hts [8] = '{16'sd0, 16'sd1, -16'sd1, 16'sd7,
                                         -16'sd7, 16'sd3, -16'sd3, 16'sd0};
    wait_quiet();
    cfg_words[REG_COEF_COL_X]    = {8'hA5, 24'h008000};
    cfg_words[REG_COEF_ROW_X]    = 32'hFFFF8000;
    cfg_words[REG_COEF_HEIGHT_X] = 32'h00004000;
    cfg_words[REG_COEF_COL_Y]    = 32'h00FFFFFF;
    cfg_words[REG_COEF_ROW_Y]    = 32'h00000001;
    cfg_words[REG_COEF_HEIGHT_Y] = 32'h00010000;
    cfg_words[REG_OFFSET_X]      = 32'hFFFFFFFF;
    cfg_words[REG_OFFSET_Y]      = 32'h00018000;
    program_regs();
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 4; c++)
        send_point(10'(c), 10'(r), hts[r * 4 + c]);
  endtask

  // Mostly raster sub-grids with random content, some scattered points.
  task automatic test_random_stream(input int style, input bit calm, input int n_items);
    int sent, w, h, c0, r0, burst;
    wait_quiet();
    random_config(style);
    program_regs();
    steady = calm;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        w  = $urandom_range(1, 12);
        h  = $urandom_range(1, 8);
        c0 = ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_COLS - w) : 0;
        r0 = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1024 - h) : 0;
        for (int j = 0; j < h; j++)
          for (int i = 0; i < w; i++)
            send_point(10'(c0 + i), 10'(r0 + j), rand_height());
        sent += w * h;
      end else begin
        burst = $urandom_range(1, 6);
        repeat (burst)
          send_point(($urandom_range(0, 1) == 1) ? 10'($urandom_range(0, 15)) : 10'($urandom),
                     10'($urandom), 16'($urandom));
        sent += burst;
      end
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_segments.size() == 0) begin
        $error("segment word arrived with nothing pending");
        mismatches++;
      end else begin
        head_seg = pending_segments.pop_front();
        check_field("begin_x", head_seg.begin_x, $signed(m_tdata[15:0]));
        check_field("begin_y", head_seg.begin_y, $signed(m_tdata[31:16]));
        check_field("end_x", head_seg.end_x, $signed(m_tdata[47:32]));
        check_field("end_y", head_seg.end_y, $signed(m_tdata[63:48]));
        check_field("edge_kind", head_seg.kind, m_tuser[0]);
        check_field("last_of_run", head_seg.last_of_run, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) reg_val[i] = 0;
    left_valid = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) col_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_grid_edges();
    test_fraction_floor();
    test_random_stream(0, 1'b0, 100);
    test_random_stream(1, 1'b0, 100);
    test_random_stream(2, 1'b1, 150);
    test_random_stream(2, 1'b0, 150);
    test_random_stream(2, 1'b0, 150);
    test_random_stream(2, 1'b0, 150);
    wait_quiet();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gwe_pkg.sv
rtl/core/gwe_row_buffer.sv
rtl/core/grid_wireframe_edge_projector.sv
rtl/core/gwe_checker.sv
tb/tb_grid_wireframe_edge_projector.sv
